FILE: rtl/core/mls_pkg.sv
// ============================================================================
// mls_pkg
// Shared types and constants of the MAC learning switch.
// ============================================================================
package mls_pkg;

    localparam int MAC_W     = 48;
    localparam int PORT_W    = 4;
    localparam int MASK_W    = 16;
    localparam int NUM_PORTS = 16;
    localparam int ENTRY_W   = MAC_W + PORT_W;

    // tdata layout of the input channel
    localparam int S_PORT_LSB = 0;
    localparam int S_SRC_LSB  = S_PORT_LSB + PORT_W;
    localparam int S_DST_LSB  = S_SRC_LSB + MAC_W;
    localparam int S_TDATA_W  = ((S_DST_LSB + MAC_W + 7) / 8) * 8;

    localparam int M_TDATA_W  = MASK_W;
    localparam int M_TUSER_W  = 3;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item (clears table on a clear item)
        logic scan;      // walk the table one entry per cycle
        logic learn;     // add source if unknown and room left
        logic load_out;  // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } status_t;

    function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
        logic [MASK_W-1:0] m;
        m = '0;
        if (int'(p) < NUM_PORTS) begin
            m = MASK_W'(1) << p;
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/mls_ram.sv
// ============================================================================
// mls_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
module mls_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/mls_ctrl.sv
// ============================================================================
// mls_ctrl
// Sequencer: accept, table scan, learn, hand result to output register.
// ============================================================================
module mls_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             mode,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mls_pkg::cmd_t    cmd,
    input  mls_pkg::status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_LEARN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = mode ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN: begin
                cmd.learn  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/mls_datapath.sv
// ============================================================================
// mls_datapath
// Item registers, address table, scan compare, learn write, result register.
// ============================================================================
module mls_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [mls_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  mls_pkg::cmd_t                    cmd,
    output mls_pkg::status_t                 status,
    output logic [mls_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [mls_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // item
    logic                        mode_reg;
    logic [mls_pkg::PORT_W-1:0]  port_reg;
    logic [mls_pkg::MAC_W-1:0]   src_reg;
    logic [mls_pkg::MAC_W-1:0]   dst_reg;

    // table control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg;
    logic          rd_valid_reg;
    logic          issue;
    logic          room;

    // scan results
    logic                        src_hit_reg;
    logic                        dst_hit_reg;
    logic [mls_pkg::PORT_W-1:0]  dst_port_reg;
    logic [mls_pkg::MASK_W-1:0]  flood_reg;
    logic                        learned_reg;
    logic                        full_reg;

    // ram
    logic                         ram_we;
    logic [mls_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [mls_pkg::MAC_W-1:0]    rd_mac;
    logic [mls_pkg::PORT_W-1:0]   rd_port;

    // result
    logic                        unicast;
    logic [mls_pkg::PORT_W-1:0]  uc_port;
    logic [mls_pkg::MASK_W-1:0]  mask;
    logic [mls_pkg::MASK_W-1:0]  mask_reg;
    logic [mls_pkg::M_TUSER_W-1:0] flags_reg;

    assign room   = (count_reg < CW'(TABLE_DEPTH));
    assign issue  = cmd.scan && (idx_reg < count_reg);
    assign ram_we = cmd.learn && !src_hit_reg && room;
    assign rd_mac  = ram_rdata[mls_pkg::MAC_W-1:0];
    assign rd_port = ram_rdata[mls_pkg::ENTRY_W-1:mls_pkg::MAC_W];

    assign status.scan_done = !(idx_reg < count_reg) && !rd_valid_reg;

    mls_ram #(
        .WIDTH (mls_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({port_reg, src_reg}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_tuser) begin
            count_next = '0;
        end else if (ram_we) begin
            count_next = count_reg + CW'(1);
        end
    end

    // learned source matching dst is unicast back to the ingress port
    always_comb begin
        unicast = !mode_reg && (dst_reg != mls_pkg::MAC_BCAST)
                  && (dst_hit_reg || (learned_reg && dst_reg == src_reg));
        uc_port = dst_hit_reg ? dst_port_reg : port_reg;
        if (mode_reg) begin
            mask = '0;
        end else if (unicast) begin
            mask = mls_pkg::port_bit(uc_port);
        end else begin
            mask = flood_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_valid_reg <= issue;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg     <= s_tuser;
            port_reg     <= s_tdata[mls_pkg::S_PORT_LSB +: mls_pkg::PORT_W];
            src_reg      <= s_tdata[mls_pkg::S_SRC_LSB +: mls_pkg::MAC_W];
            dst_reg      <= s_tdata[mls_pkg::S_DST_LSB +: mls_pkg::MAC_W];
            src_hit_reg  <= 1'b0;
            dst_hit_reg  <= 1'b0;
            flood_reg    <= '0;
            learned_reg  <= 1'b0;
            full_reg     <= 1'b0;
        end else begin
            if (rd_valid_reg) begin
                if (rd_mac == src_reg) begin
                    src_hit_reg <= 1'b1;
                end else begin
                    flood_reg <= flood_reg | mls_pkg::port_bit(rd_port);
                end
                if (rd_mac == dst_reg) begin
                    dst_hit_reg  <= 1'b1;
                    dst_port_reg <= rd_port;
                end
            end
            if (cmd.learn) begin
                learned_reg <= ram_we;
                full_reg    <= !src_hit_reg && !room;
            end
        end
        if (cmd.load_out) begin
            mask_reg  <= mask;
            flags_reg <= {full_reg, learned_reg, unicast};
        end
    end

    assign m_tdata = mask_reg;
    assign m_tuser = flags_reg;

endmodule

FILE: rtl/core/mac_learning_switch_unit.sv
// ============================================================================
// mac_learning_switch_unit
// Learning Ethernet bridge: source learning and destination forwarding.
// ============================================================================
//
//  channel   dir  tdata (low bit up)                     tuser
//  s_*       in   ingress_port[3:0] src_mac dst_mac pad  mode (1 = clear table)
//  m_*       out  egress_mask[15:0]                      is_unicast src_learned
//                                                         table_full
//
//  Scan: a frame item visits every stored table entry in turn; the single read
//  port of the address RAM visits one entry a cycle. A clear item skips the
//  scan and learn states and goes straight to the done state.
//  Reset: aresetn synchronous, active low; empties the table (entry count
//  only, RAM contents are never read beyond the count).
//  Stalls: the result sits in an output register; the next item is taken
//  while it waits, and only its own finish waits for m_tready.
//
module mac_learning_switch_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] ingress_port, [51:4] src_mac, [99:52] dst_mac, [103:100] zero
    input  logic [mls_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                          s_tuser,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] egress_mask
    output logic [mls_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] is_unicast, [1] src_learned, [2] table_full
    output logic [mls_pkg::M_TUSER_W-1:0] m_tuser
);

    mls_pkg::cmd_t    cmd;
    mls_pkg::status_t status;

    // sequencing: idle -> scan -> learn -> done (clear items skip to done)
    mls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // table RAM, scan compare against src and dst, result register
    mls_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: rtl/core/mls_checker.sv
// ============================================================================
// mls_checker
// Port-level checks of the MAC learning switch.
// ============================================================================
module mls_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mls_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mls_pkg::M_TUSER_W-1:0] m_tuser
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // unicast goes to at most one port
    a_uc_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> $onehot0(m_tdata))
        else $error("unicast to several ports");

    // learned and table full never together
    a_learn_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("learned and table full both set");

    // a clear item's result is not offered at once: it passes the done state and the output register first
    a_clear_late: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("clear result too early");

endmodule

bind mac_learning_switch_unit mls_checker u_mls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
